/* rtl/pic_pkg.sv */
package pic_pkg;

	// Widths of the data path and of the stream buses.
	localparam int DataW   = 32;
	localparam int StampW  = 64;
	localparam int CfgIdxW = 2;
	localparam int InW     = 2 * DataW + StampW;
	localparam int OutW    = DataW + StampW;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_KP_GAIN     = 2'd0,
		REG_KI_PER_TICK = 2'd1,
		REG_LOWER_MAG   = 2'd2,
		REG_UPPER_LIMIT = 2'd3
	} reg_idx_t;

	// Register set as seen by the data path.
	typedef struct packed {
		logic signed [DataW-1:0] kp_gain;
		logic signed [DataW-1:0] ki_per_tick;
		logic        [DataW-2:0] windup_lower_magnitude;
		logic signed [DataW-1:0] windup_upper_limit;
	} cfg_t;

endpackage

/* rtl/pic_cfg.sv */
module pic_cfg import pic_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain                <= '0;
			cfg_q.ki_per_tick            <= '0;
			cfg_q.windup_lower_magnitude <= '1;
			cfg_q.windup_upper_limit     <= {1'b0, {(DataW-1){1'b1}}};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_KP_GAIN:     cfg_q.kp_gain                <= cfg_data;
				REG_KI_PER_TICK: cfg_q.ki_per_tick            <= cfg_data;
				REG_LOWER_MAG:   cfg_q.windup_lower_magnitude <= cfg_data[DataW-2:0];
				REG_UPPER_LIMIT: cfg_q.windup_upper_limit     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/pic_mul.sv */
module pic_mul import pic_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DataW-1:0]     a,
	input  logic [DataW-1:0]     b,
	output logic [2*DataW-1:0]   prod
);

	logic [2*DataW-1:0] prod_q;

	// Unsigned product, registered so that nothing follows the multiplier
	// in the same cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {{DataW{1'b0}}, a} * {{DataW{1'b0}}, b};
		end
	end

	assign prod = prod_q;

endmodule

/* rtl/pi_controller_clamped_integral.sv */
// PI controller with a clamped integral term, one channel, Q16.16 data. Each input
// transfer carries a reference, a measurement and a timestamp in ticks; each one yields
// exactly one output transfer with the drive value, a clamp flag and the timestamp. The
// integral accumulates error times elapsed ticks in a saturating 64-bit sum (no time
// elapses on the first item after reset, nor when the timestamp goes backwards); the
// integral term ki_per_tick * sum / 2^48 is limited to the range from minus
// windup_lower_magnitude to windup_upper_limit, the lower limit being tested first.
// All products are built on one shared 32 x 32 bit multiplier under a small sequencer,
// five products per item; a taken item holds the block until its result is in the
// output register, and no new item is taken before then. The result sits in an
// output register, so the next input transfer is taken while it waits; the block only
// stalls when a second result is ready before the first has been taken. Configuration
// registers are written through the plain write port and must only be changed while
// the block is idle.
module pi_controller_clamped_integral import pic_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_data,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [InW-1:0]     s_tdata,   // reference [31:0], measurement [63:32], timestamp [127:64]
	// output stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OutW-1:0]    m_tdata,   // drive [31:0], stamp_out [95:32]
	output logic               m_tuser    // integral_clamped [0]
);

	localparam int ProdW = 2 * DataW;      // width of one multiplier product
	localparam int MagW  = ProdW - 16;     // width of a rounded gain product magnitude
	localparam int TermW = MagW + 1;       // signed gain product
	localparam int SumW  = TermW + 1;      // proportional plus integral term

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MLO,
		ST_MHI,
		ST_INC,
		ST_ACC,
		ST_MAG,
		ST_KLO,
		ST_KHI,
		ST_TERM,
		ST_SIGN,
		ST_CLAMP,
		ST_SUM
	} state_t;

	state_t state_q;

	cfg_t cfg;

	pic_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Item registers.
	logic [DataW-1:0]  ref_q;
	logic [DataW-1:0]  meas_q;
	logic [StampW-1:0] stamp_q;

	// State kept between items.
	logic [StampW-1:0] prev_q;
	logic              first_q;
	logic [ProdW-1:0]  integral_q;

	// Working registers.
	logic [DataW-1:0]  err_mag_q;
	logic              err_neg_q;
	logic [StampW-1:0] dt_q;
	logic [DataW-1:0]  kp_mag_q;
	logic [DataW-1:0]  ki_mag_q;
	logic [ProdW-1:0]  lo_q;
	logic [ProdW-1:0]  incm_q;
	logic [ProdW-1:0]  imag_q;
	logic              tneg_q;
	logic [MagW-1:0]   ppm_q;
	logic [MagW-1:0]   tmag_q;
	logic [TermW-1:0]  prop_q;
	logic [TermW-1:0]  term_q;
	logic [TermW-1:0]  low_q;
	logic [TermW-1:0]  termc_q;
	logic              clamped_q;

	// Output register.
	logic              m_valid_q;
	logic [DataW-1:0]  drive_q;
	logic              flag_q;
	logic [StampW-1:0] stamp_out_q;

	// Shared multiplier.
	logic              mul_en;
	logic [DataW-1:0]  mul_a;
	logic [DataW-1:0]  mul_b;
	logic [ProdW-1:0]  prod;

	pic_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_comb begin
		mul_en = 1'b1;
		mul_a  = err_mag_q;
		mul_b  = dt_q[DataW-1:0];
		case (state_q)
			ST_MLO: begin
				mul_a = err_mag_q;
				mul_b = dt_q[DataW-1:0];
			end
			ST_MHI: begin
				mul_a = err_mag_q;
				mul_b = dt_q[StampW-1:DataW];
			end
			ST_INC: begin
				mul_a = kp_mag_q;
				mul_b = err_mag_q;
			end
			ST_KLO: begin
				mul_a = ki_mag_q;
				mul_b = imag_q[DataW-1:0];
			end
			ST_KHI: begin
				mul_a = ki_mag_q;
				mul_b = imag_q[ProdW-1:DataW];
			end
			default: mul_en = 1'b0;
		endcase
	end

	// Error and elapsed time.
	logic [DataW:0]    diff_rm;
	logic [DataW:0]    diff_mr;
	logic              ref_lt;
	logic [StampW:0]   dt_diff;

	assign diff_rm = {ref_q[DataW-1], ref_q} - {meas_q[DataW-1], meas_q};
	assign diff_mr = {meas_q[DataW-1], meas_q} - {ref_q[DataW-1], ref_q};
	assign ref_lt  = $signed(ref_q) < $signed(meas_q);
	assign dt_diff = {1'b0, stamp_q} - {1'b0, prev_q};

	// Upper half of a 96-bit product: high partial product plus the carry
	// half of the low one. For the integral term the rounding half (2^47)
	// is folded in here as well.
	logic [ProdW-1:0]  hi_inc;
	logic [ProdW-1:0]  hi_term;
	logic              inc_big;
	logic [ProdW-1:0]  prop_rnd;

	assign hi_inc   = prod + {{DataW{1'b0}}, lo_q[ProdW-1:DataW]};
	assign hi_term  = prod + {{DataW{1'b0}}, lo_q[ProdW-1:DataW]} + ProdW'(1 << 15);
	assign inc_big  = |hi_inc[ProdW-1:DataW-1];
	assign prop_rnd = prod + ProdW'(1 << 15);

	// Saturating accumulation: the increment is added with its sign applied
	// through inversion and carry-in.
	logic [ProdW:0]    inc_add;
	logic [ProdW+1:0]  acc_sum;

	assign inc_add = {1'b0, incm_q} ^ {(ProdW+1){err_neg_q}};
	assign acc_sum = {{2{integral_q[ProdW-1]}}, integral_q} + {inc_add[ProdW], inc_add}
		+ {{(ProdW+1){1'b0}}, err_neg_q};

	// Clamp limits and final sum.
	logic [TermW-1:0]  upper_ext;
	logic [SumW-1:0]   drive_sum;

	assign upper_ext = {{(TermW-DataW){cfg.windup_upper_limit[DataW-1]}}, cfg.windup_upper_limit};
	assign drive_sum = {prop_q[TermW-1], prop_q} + {termc_q[TermW-1], termc_q};

	logic              out_free;
	assign out_free = !m_valid_q || m_tready;

	// Sequencer, state across items and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			first_q     <= 1'b1;
			integral_q  <= '0;
			m_valid_q   <= 1'b0;
			drive_q     <= '0;
			flag_q      <= 1'b0;
			stamp_out_q <= '0;
		end else begin
			// A new result is loaded as the old one leaves or once the register is empty.
			if (state_q == ST_SUM && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					prev_q  <= stamp_q;
					first_q <= 1'b0;
					state_q <= ST_MLO;
				end
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_INC;
				ST_INC:  state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_sum[ProdW+1:ProdW-1] == 3'b000 ||
						acc_sum[ProdW+1:ProdW-1] == 3'b111) begin
						integral_q <= acc_sum[ProdW-1:0];
					end else if (acc_sum[ProdW+1]) begin
						integral_q <= {1'b1, {(ProdW-1){1'b0}}};
					end else begin
						integral_q <= {1'b0, {(ProdW-1){1'b1}}};
					end
					state_q <= ST_MAG;
				end
				ST_MAG:   state_q <= ST_KLO;
				ST_KLO:   state_q <= ST_KHI;
				ST_KHI:   state_q <= ST_TERM;
				ST_TERM:  state_q <= ST_SIGN;
				ST_SIGN:  state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_SUM;
				ST_SUM: begin
					if (out_free) begin
						flag_q      <= clamped_q;
						stamp_out_q <= stamp_q;
						if (drive_sum[SumW-1:DataW-1] == '0 ||
							drive_sum[SumW-1:DataW-1] == '1) begin
							drive_q <= drive_sum[DataW-1:0];
						end else if (drive_sum[SumW-1]) begin
							drive_q <= {1'b1, {(DataW-1){1'b0}}};
						end else begin
							drive_q <= {1'b0, {(DataW-1){1'b1}}};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ref_q   <= s_tdata[DataW-1:0];
					meas_q  <= s_tdata[2*DataW-1:DataW];
					stamp_q <= s_tdata[InW-1:2*DataW];
				end
			end
			ST_PREP: begin
				// The difference of two 32-bit values has a magnitude below 2^32.
				err_neg_q <= ref_lt;
				err_mag_q <= ref_lt ? diff_mr[DataW-1:0] : diff_rm[DataW-1:0];
				dt_q      <= (first_q || dt_diff[StampW]) ? '0 : dt_diff[StampW-1:0];
				kp_mag_q  <= cfg.kp_gain[DataW-1] ? (DataW'(0) - cfg.kp_gain) : cfg.kp_gain;
				ki_mag_q  <= cfg.ki_per_tick[DataW-1] ?
					(DataW'(0) - cfg.ki_per_tick) : cfg.ki_per_tick;
			end
			ST_MHI: lo_q <= prod;
			ST_INC: begin
				// Magnitude of the increment, held at the signed 64-bit limit.
				if (inc_big) begin
					incm_q <= err_neg_q ? {1'b1, {(ProdW-1){1'b0}}} : {1'b0, {(ProdW-1){1'b1}}};
				end else begin
					incm_q <= {hi_inc[DataW-1:0], lo_q[DataW-1:0]};
				end
			end
			ST_ACC: ppm_q <= prop_rnd[ProdW-1:16];
			ST_MAG: begin
				imag_q <= integral_q[ProdW-1] ? (ProdW'(0) - integral_q) : integral_q;
				tneg_q <= cfg.ki_per_tick[DataW-1] ^ integral_q[ProdW-1];
			end
			ST_KHI:  lo_q   <= prod;
			ST_TERM: tmag_q <= hi_term[ProdW-1:16];
			ST_SIGN: begin
				term_q <= tneg_q ? (TermW'(0) - {1'b0, tmag_q}) : {1'b0, tmag_q};
				prop_q <= (cfg.kp_gain[DataW-1] ^ err_neg_q) ?
					(TermW'(0) - {1'b0, ppm_q}) : {1'b0, ppm_q};
				low_q  <= TermW'(0) - {{(TermW-DataW+1){1'b0}}, cfg.windup_lower_magnitude};
			end
			ST_CLAMP: begin
				// Lower limit first, so with crossed limits a term below the lower one resolves to it.
				if ($signed(term_q) < $signed(low_q)) begin
					termc_q   <= low_q;
					clamped_q <= 1'b1;
				end else if ($signed(term_q) > $signed(upper_ext)) begin
					termc_q   <= upper_ext;
					clamped_q <= 1'b1;
				end else begin
					termc_q   <= term_q;
					clamped_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {stamp_out_q, drive_q};
	assign m_tuser  = flag_q;

endmodule

/* test/pi_controller_clamped_integral_tb.sv */
module pi_controller_clamped_integral_tb import pic_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// The run is stopped here whatever happens. Even with every long gap and stall a correct
	// run stays far below this.
	localparam int unsigned CycleLimit = 1_000_000;
	localparam logic signed [63:0] Int64Max = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] Int64Min = 64'sh8000_0000_0000_0000;
	localparam logic [31:0] Q16Max = 32'h7fff_ffff;
	localparam logic [31:0] Q16Min = 32'h8000_0000;
	localparam logic [31:0] Q16One = 32'h0001_0000;

	// One result as it should leave the block.
	typedef struct {
		logic signed [31:0] drive;
		logic               clamped;
		logic [63:0]        stamp;
	} ctl_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	reg_idx_t          cfg_index = REG_KP_GAIN;
	logic [DataW-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [InW-1:0]    s_tdata = '0;   // reference [31:0], measurement [63:32], timestamp [127:64]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OutW-1:0]   m_tdata;        // drive [31:0], stamp_out [95:32]
	logic              m_tuser;        // integral_clamped [0]

	// Our own copy of the register set and of the controller state, kept in step with
	// the block: registers change when they are written, the state when an input
	// transfer is taken.
	logic signed [31:0] kp_m = '0;
	logic signed [31:0] ki_m = '0;
	logic [30:0]        lower_mag_m = '1;
	logic signed [31:0] upper_m = 32'sh7fff_ffff;
	logic signed [63:0] integral_m = '0;
	logic [63:0]        prev_stamp_m = '0;
	logic               first_m = 1'b1;

	// Results still owed by the block, oldest first.
	ctl_result_t expected_results[$];

	int unsigned cycles = 0;
	int unsigned sent_count = 0;
	int unsigned checked_count = 0;
	int unsigned clamp_count = 0;
	int unsigned rail_count = 0;
	int unsigned settings_count = 0;
	int unsigned errors = 0;

	// Stimulus side: the last timestamp offered, and the knobs for idling on both sides.
	logic [63:0] last_stamp = '0;
	bit          src_idle_en = 1'b1;
	bit          sink_idle_en = 1'b1;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;

	pi_controller_clamped_integral u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles,
				expected_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Magnitude product reduced by 2^sh, rounded to nearest with ties away from zero,
	// then given the sign of the product. Both gain terms go through this.
	function automatic logic signed [63:0] round_product(logic signed [63:0] k,
			logic signed [63:0] a, int unsigned sh);
		logic [127:0] km;
		logic [127:0] am;
		logic [127:0] p;
		logic [63:0]  m;
		km = {64'd0, (k < 0) ? -k : k};
		am = {64'd0, (a < 0) ? -a : a};
		p = km * am + (128'd1 << (sh - 1));
		m = 64'(p >> sh);
		return ((k < 0) != (a < 0)) ? -$signed(m) : $signed(m);
	endfunction

	// Works out the result of one accepted item and advances the controller state.
	function automatic ctl_result_t predict_output(logic signed [31:0] setpoint,
			logic signed [31:0] plant, logic [63:0] stamp);
		logic signed [63:0] err;
		logic signed [63:0] inc;
		logic signed [63:0] term;
		logic signed [63:0] lower;
		logic signed [63:0] prop;
		logic signed [63:0] total;
		logic [63:0]        em;
		logic [63:0]        dt;
		logic [127:0]       wide;
		logic [64:0]        acc;
		ctl_result_t        r;
		err = setpoint;
		err = err - plant;
		// No time passes on the first item, nor when the clock runs backwards.
		dt = '0;
		if (first_m)
			first_m = 1'b0;
		else if (stamp >= prev_stamp_m)
			dt = stamp - prev_stamp_m;
		em = (err < 0) ? -err : err;
		wide = {64'd0, em} * {64'd0, dt};
		if (wide[127:64] != 0)
			wide[63:0] = '1;
		if (err >= 0)
			inc = wide[63] ? Int64Max : $signed(wide[63:0]);
		else
			inc = wide[63] ? Int64Min : -$signed(wide[63:0]);
		acc = {integral_m[63], integral_m} + {inc[63], inc};
		case (acc[64:63])
			2'b01: integral_m = Int64Max;
			2'b10: integral_m = Int64Min;
			default: integral_m = acc[63:0];
		endcase
		// Lower limit first, so crossed limits settle on the lower one only when the
		// term lies below it.
		term = round_product(ki_m, integral_m, 48);
		lower = -$signed({33'd0, lower_mag_m});
		r.clamped = 1'b1;
		if (term < lower)
			term = lower;
		else if (term > upper_m)
			term = upper_m;
		else
			r.clamped = 1'b0;
		prop = round_product(kp_m, err, 16);
		total = prop + term;
		if (total > 64'sh7fff_ffff)
			r.drive = 32'sh7fff_ffff;
		else if (total < -64'sh8000_0000)
			r.drive = 32'sh8000_0000;
		else
			r.drive = total[31:0];
		r.stamp = stamp;
		prev_stamp_m = stamp;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (errors < 40)
			$display("mismatch at cycle %0d: %s, got %h, expected %h", cycles, what, got, want);
		errors++;
	endtask

	// Scoreboard. Input transfers are predicted at the edge that takes them; output
	// transfers are compared with the oldest prediction at the edge that moves them.
	always @(posedge clk) begin
		ctl_result_t want;
		if (arst_n && s_tvalid && s_tready) begin
			expected_results.push_back(predict_output(s_tdata[31:0], s_tdata[63:32],
				s_tdata[127:64]));
			sent_count++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item outstanding, stamp", m_tdata[95:32], '0);
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				if (m_tdata[31:0] !== want.drive)
					report_mismatch("drive", m_tdata[31:0], want.drive);
				if (m_tuser !== want.clamped)
					report_mismatch("clamp flag", m_tuser, want.clamped);
				if (m_tdata[95:32] !== want.stamp)
					report_mismatch("stamp", m_tdata[95:32], want.stamp);
				if (want.clamped)
					clamp_count++;
				if (want.drive == 32'sh7fff_ffff || want.drive == 32'sh8000_0000)
					rail_count++;
			end
		end
	end

	// Receiver. A requested hold is counted down here cycle by cycle; otherwise the
	// ready line drops for random stretches when idling is enabled.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (sink_idle_en && $urandom_range(0, 99) < 30) begin
				m_tready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Register writes are only issued while the block is idle. The model follows each
	// write once the edge that takes it has passed.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_KP_GAIN:     kp_m = value;
			REG_KI_PER_TICK: ki_m = value;
			REG_LOWER_MAG:   lower_mag_m = value[30:0];
			REG_UPPER_LIMIT: upper_m = value;
			default: ;
		endcase
	endtask

	task automatic program_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] lower_mag,
			logic [31:0] upper);
		write_reg(REG_KP_GAIN, kp);
		write_reg(REG_KI_PER_TICK, ki);
		write_reg(REG_LOWER_MAG, lower_mag);
		write_reg(REG_UPPER_LIMIT, upper);
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	// Offers one item after an optional gap and returns once the transfer has happened.
	// The valid line is left high so that a following item can go out back to back.
	task automatic send_item(logic [31:0] setpoint, logic [31:0] plant, logic [63:0] stamp);
		int unsigned gap;
		gap = src_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {stamp, plant, setpoint};
		do @(posedge clk); while (!s_tready);
		last_stamp = stamp;
	endtask

	// Stops offering items and waits until every owed result has come out.
	task automatic wait_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return Q16Max;
			1: return Q16Min;
			2: return '0;
			3, 4: return $urandom;
			default: return 32'($signed($urandom) >>> $urandom_range(8, 30));
		endcase
	endfunction

	// Mostly a plant that follows its setpoint, giving small errors of either sign.
	function automatic logic [31:0] pick_plant(logic [31:0] setpoint);
		if ($urandom_range(0, 99) < 60)
			return setpoint - 32'($signed($urandom) >>> $urandom_range(10, 30));
		return pick_sample();
	endfunction

	// Timestamps mostly move forward by modest steps; now and then they stand still, jump,
	// run backwards or land anywhere at all.
	function automatic logic [63:0] pick_stamp(logic [63:0] prev);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return {$urandom, $urandom};
		if (r < 6)
			return prev - $urandom_range(1, 5000);
		if (r < 10)
			return prev;
		if (r < 15)
			return prev + ({$urandom, $urandom} >> $urandom_range(16, 40));
		return prev + $urandom_range(1, 1 << $urandom_range(0, 16));
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return Q16Min;
			1: return Q16Max;
			2: return '0;
			3: return Q16One;
			default: return 32'($signed($urandom) >>> $urandom_range(0, 20));
		endcase
	endfunction

	// The top bit is junk on purpose: only 31 bits of the lower magnitude are kept.
	function automatic logic [31:0] pick_lower_mag();
		logic [30:0] mag;
		case ($urandom_range(0, 5))
			0: mag = '0;
			1: mag = '1;
			default: mag = 31'($urandom >> $urandom_range(1, 24));
		endcase
		return {1'($urandom_range(0, 1)), mag};
	endfunction

	function automatic logic [31:0] pick_upper();
		case ($urandom_range(0, 5))
			0: return Q16Max;
			1: return Q16Min;
			2: return '0;
			default: return 32'($signed($urandom) >>> $urandom_range(1, 24));
		endcase
	endfunction

	// With both gains at their reset value of zero the drive stays at zero, and the very
	// first item after reset contributes nothing to the integral even with a large stamp.
	task automatic test_power_up_defaults();
		send_item(Q16Max, Q16Min, 64'd1000);
		send_item(Q16One, 32'd0, 64'd1500);
		wait_results();
	endtask

	// Unit proportional gain and an integral term of sum / 2^24, limited to -16.0 .. 8.0.
	// Walks through a small error, full-scale errors that drive both the term and the
	// drive into their limits, a stamp that stands still, one that runs backwards and
	// a step to the very top of the tick range that overflows the increment.
	task automatic test_integral_and_saturation();
		program_gains(Q16One, 32'h0100_0000, 32'h0010_0000, 32'h0008_0000);
		send_item(Q16One, 32'd0, 64'd2000);
		send_item(Q16Max, Q16Min, 64'd2000 + 64'd1048576);
		send_item(Q16Min, Q16Max, 64'h0000_0100_0000_0000);
		send_item(32'd0, 32'd0, 64'h0000_0100_0000_0000);
		send_item(32'h0002_0000, 32'd0, 64'd5);
		send_item(Q16Max, Q16Min, 64'hffff_ffff_ffff_ffff);
		send_item(Q16Max, Q16Min, 64'hffff_ffff_ffff_ffff);
		send_item(Q16Min, Q16Max, 64'd0);
		wait_results();
	endtask

	// Upper limit below minus the lower magnitude: the order of the two tests decides.
	task automatic test_crossed_limits();
		program_gains(32'd0, 32'h0100_0000, 32'd100, 32'hffff_ff38);
		send_item(32'd0, 32'd0, last_stamp + 64'd1);
		send_item(Q16Min, Q16Max, last_stamp + 64'h4000_0000);
		send_item(Q16Max, Q16Min, last_stamp + 64'h8000_0000);
		wait_results();
	endtask

	// A half gain on errors of one and three LSBs lands exactly on ties, which must round
	// away from zero in both directions.
	task automatic test_rounding_ties();
		program_gains(32'h0000_8000, 32'd0, 32'h7fff_ffff, Q16Max);
		send_item(32'd1, 32'd0, last_stamp + 64'd1);
		send_item(32'd0, 32'd1, last_stamp + 64'd1);
		send_item(32'd3, 32'd0, last_stamp + 64'd1);
		send_item(32'd0, 32'd3, last_stamp + 64'd1);
		wait_results();
	endtask

	// Both gains and both limits at their extremes, in each direction.
	task automatic test_gain_extremes();
		program_gains(Q16Min, Q16Max, 32'd0, Q16Min);
		send_item(Q16Max, Q16Min, last_stamp + 64'd7);
		send_item(Q16Min, Q16Max, last_stamp + 64'd1000);
		send_item(32'd0, 32'd0, last_stamp + 64'd1);
		wait_results();
		program_gains(Q16Max, Q16Min, 32'h7fff_ffff, Q16Max);
		send_item(Q16Min, Q16Max, last_stamp + 64'd3);
		send_item(Q16Max, 32'd0, last_stamp + (64'd1 << 40));
		wait_results();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering items
	// back to back, so the output register fills and the block has to stall its input.
	task automatic test_backpressure();
		int unsigned n;
		src_idle_en = 1'b0;
		hold_left = 300;
		for (n = 0; n < 12; n++)
			send_item(pick_sample(), pick_sample(), pick_stamp(last_stamp));
		wait_results();
		src_idle_en = 1'b1;
	endtask

	// Random register settings, each followed by a long run of random items. Each phase
	// opens with one item that pulls the integral back near zero, so that the sum does
	// not sit on a rail for the whole phase and mid-range terms are seen as well.
	task automatic test_random_phases(int unsigned phases, int unsigned per_phase);
		int unsigned p;
		int unsigned n;
		logic [31:0] setpoint;
		for (p = 0; p < phases; p++) begin
			program_gains(pick_gain(), pick_gain(), pick_lower_mag(), pick_upper());
			src_idle_en = (p % 3) != 2;
			sink_idle_en = (p % 4) != 3;
			if (integral_m > 0)
				send_item(Q16Min, Q16Max, last_stamp + $unsigned(integral_m) / 64'hffff_ffff);
			else
				send_item(Q16Max, Q16Min, last_stamp + $unsigned(-integral_m) / 64'hffff_ffff);
			for (n = 0; n < per_phase; n++) begin
				setpoint = pick_sample();
				send_item(setpoint, pick_plant(setpoint), pick_stamp(last_stamp));
			end
			wait_results();
		end
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_power_up_defaults();
		test_integral_and_saturation();
		test_crossed_limits();
		test_rounding_ties();
		test_gain_extremes();
		test_backpressure();
		test_random_phases(7, 195);
		wait_results();
		// Allow time for anything the block might still send unasked.
		repeat (30) @(posedge clk);
		$display("covered %0d input transfers, %0d results checked, %0d register settings",
			sent_count, checked_count, settings_count);
		$display("integral term clamped on %0d results, drive at a rail on %0d", clamp_count,
			rail_count);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
